### hdl/safe_box_corridor_grower_assert.svh
// assertion macros shared by the rtl
`ifndef SAFE_BOX_CORRIDOR_GROWER_ASSERT_SVH
`define SAFE_BOX_CORRIDOR_GROWER_ASSERT_SVH
// property checked at every rising clock edge outside reset
`define SBCG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

### hdl/sbcg_pkg.sv
package sbcg_pkg;
	localparam int MaxObstacles = 64;
	localparam int CoordBits = 20;
	localparam int CfgIdxBits = 3;
	localparam int CfgDataBits = 20;
	localparam int RadBits = 16;
	localparam int LenBits = 20;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [CfgIdxBits-1:0] REG_MAP_W = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_MAP_H = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_VEH_R = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_STEP = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_LIMIT = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic add;
		logic start;
		logic rd_req;
		logic check;
		logic commit;
		logic reject;
		logic load_out;
		logic emit;
	} sbcg_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_obst;
		logic no_obst;
		logic hit;
		logic map_ok;
		logic any_active;
	} sbcg_sts_t;
endpackage

### hdl/sbcg_in_if.sv
interface sbcg_in_if import sbcg_pkg::*; #(parameter int COORD_BITS = CoordBits);
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [COORD_BITS-1:0] obstacle_x;
	logic [COORD_BITS-1:0] obstacle_y;
	logic [RadBits-1:0] obstacle_radius;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	modport source (output valid, opcode, obstacle_x, obstacle_y, obstacle_radius,
		point_x, point_y, input ready);
	modport sink (input valid, opcode, obstacle_x, obstacle_y, obstacle_radius,
		point_x, point_y, output ready);
endinterface

### hdl/sbcg_out_if.sv
interface sbcg_out_if import sbcg_pkg::*; #(parameter int COORD_BITS = CoordBits);
	logic valid;
	logic ready;
	logic signed [COORD_BITS:0] box_x_min;
	logic signed [COORD_BITS:0] box_y_min;
	logic signed [COORD_BITS:0] box_x_max;
	logic signed [COORD_BITS:0] box_y_max;
	logic grew_any;
	modport source (output valid, box_x_min, box_y_min, box_x_max, box_y_max, grew_any,
		input ready);
	modport sink (input valid, box_x_min, box_y_min, box_x_max, box_y_max, grew_any,
		output ready);
endinterface

### hdl/safe_box_corridor_grower.sv
// channel  dir  payload
// in_ch    in   opcode, obstacle x/y/radius, point x/y
// out_ch   out  four box edges, grew_any
// cfg      in   cfg_we, cfg_idx, cfg_data
// clear and add act on acceptance; a query runs trials until no direction stays active
// each trial reads, then checks, each obstacle memory entry in turn through its read port
// arst_n clears control state; the obstacle memory holds no reset
// a finished query holds in its last state while the output register still waits on out_ch
module safe_box_corridor_grower import sbcg_pkg::*; #(
	parameter int MAX_OBSTACLES = MaxObstacles,
	parameter int COORD_BITS = CoordBits
) (
	input logic clk,
	input logic arst_n,
	sbcg_in_if.sink in_ch,
	sbcg_out_if.source out_ch,
	input logic cfg_we,
	input logic [CfgIdxBits-1:0] cfg_idx,
	input logic [CfgDataBits-1:0] cfg_data
);
	logic [LenBits-1:0] map_w_q, map_h_q, limit_q;
	logic [RadBits-1:0] veh_r_q, step_q;
	sbcg_cmd_t cmd;
	sbcg_sts_t sts;
	logic [4*(COORD_BITS+1)-1:0] box_flat;
	logic grew;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= 20'd256000;
			map_h_q <= 20'd256000;
			veh_r_q <= 16'd256;
			step_q <= 16'd26;
			limit_q <= 20'd1280;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAP_W: map_w_q <= cfg_data;
				REG_MAP_H: map_h_q <= cfg_data;
				REG_VEH_R: veh_r_q <= cfg_data[RadBits-1:0];
				REG_STEP: step_q <= cfg_data[RadBits-1:0];
				REG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sbcg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.opcode(in_ch.opcode), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	sbcg_datapath #(.MAX_OBSTACLES(MAX_OBSTACLES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.obstacle_x(in_ch.obstacle_x), .obstacle_y(in_ch.obstacle_y),
		.obstacle_radius(in_ch.obstacle_radius), .point_x(in_ch.point_x),
		.point_y(in_ch.point_y), .map_width(map_w_q), .map_height(map_h_q),
		.vehicle_radius(veh_r_q), .grow_step(step_q), .grow_limit(limit_q),
		.box_flat(box_flat), .grew(grew)
	);

	// result fields from the output register
	assign out_ch.box_x_min = box_flat[0 +: COORD_BITS+1];
	assign out_ch.box_y_min = box_flat[(COORD_BITS+1) +: COORD_BITS+1];
	assign out_ch.box_x_max = box_flat[2*(COORD_BITS+1) +: COORD_BITS+1];
	assign out_ch.box_y_max = box_flat[3*(COORD_BITS+1) +: COORD_BITS+1];
	assign out_ch.grew_any = grew;
endmodule

### hdl/sbcg_datapath.sv
module sbcg_datapath import sbcg_pkg::*; #(
	parameter int MAX_OBSTACLES = MaxObstacles,
	parameter int COORD_BITS = CoordBits
) (
	input logic clk,
	input logic arst_n,
	input sbcg_cmd_t cmd,
	output sbcg_sts_t sts,
	input logic [COORD_BITS-1:0] obstacle_x,
	input logic [COORD_BITS-1:0] obstacle_y,
	input logic [RadBits-1:0] obstacle_radius,
	input logic [COORD_BITS-1:0] point_x,
	input logic [COORD_BITS-1:0] point_y,
	input logic [LenBits-1:0] map_width,
	input logic [LenBits-1:0] map_height,
	input logic [RadBits-1:0] vehicle_radius,
	input logic [RadBits-1:0] grow_step,
	input logic [LenBits-1:0] grow_limit,
	output logic [4*(COORD_BITS+1)-1:0] box_flat,
	output logic grew
);
	localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW = $clog2(MAX_OBSTACLES + 1);
	localparam int OW = 2 * COORD_BITS + RadBits;
	// wide signed working width, enough for all sums
	localparam int WW = (COORD_BITS > LenBits ? COORD_BITS : LenBits) + 4;

	logic [OW-1:0] mem [MAX_OBSTACLES];
	logic [OW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic signed [WW-1:0] box_q [4];
	logic signed [WW-1:0] trial_q [4];
	logic [WW-1:0] glen_q [4];
	logic [COORD_BITS:0] obox_q [4];
	logic [3:0] act_q;
	logic [1:0] dir_q;
	logic grew_q, hit_q, ogrew_q;

	// obstacle memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.add && count_q < CW'(MAX_OBSTACLES))
			mem[count_q[AW-1:0]] <= {obstacle_x, obstacle_y, obstacle_radius};
		if (cmd.rd_req)
			rd_q <= mem[ptr_q[AW-1:0]];
	end

	// trial box from the current box and direction
	logic signed [WW-1:0] stp;
	logic signed [WW-1:0] tb [4];
	assign stp = WW'(grow_step);
	always_comb begin
		for (int i = 0; i < 4; i++) tb[i] = box_q[i];
		case (dir_q)
			2'd0: tb[3] = box_q[3] + stp;
			2'd1: tb[0] = box_q[0] - stp;
			2'd2: tb[1] = box_q[1] - stp;
			default: tb[2] = box_q[2] + stp;
		endcase
	end

	// map check on the stored trial
	logic signed [WW-1:0] rv, mw, mh;
	assign rv = WW'(vehicle_radius);
	assign mw = WW'(map_width);
	assign mh = WW'(map_height);
	assign sts.map_ok = !(trial_q[0] < rv || trial_q[2] > mw - rv ||
		trial_q[1] < rv || trial_q[3] > mh - rv);

	// obstacle check on the read entry
	logic signed [WW-1:0] ox, oy, om;
	logic obst_hit;
	assign ox = WW'(rd_q[OW-1 -: COORD_BITS]);
	assign oy = WW'(rd_q[RadBits +: COORD_BITS]);
	assign om = WW'(rd_q[RadBits-1:0]) + rv;
	assign obst_hit = (trial_q[0] - om < ox) && (ox < trial_q[2] + om) &&
		(trial_q[1] - om < oy) && (oy < trial_q[3] + om);

	// ptr_q has already moved past the entry under check
	assign sts.hit = hit_q;
	assign sts.no_obst = (count_q == '0);
	assign sts.last_obst = (ptr_q >= count_q);
	assign sts.any_active = |act_q;

	// next active direction after the current one, wrapping
	logic [1:0] nd;
	always_comb begin
		nd = dir_q;
		for (int k = 4; k >= 1; k--)
			if (act_q[2'(dir_q + 2'(k))]) nd = 2'(dir_q + 2'(k));
	end

	logic [WW-1:0] gl_new;
	assign gl_new = glen_q[dir_q] + WW'(grow_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			act_q <= '0;
			dir_q <= '0;
			grew_q <= 1'b0;
			hit_q <= 1'b0;
			ogrew_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				box_q[i] <= '0;
				trial_q[i] <= '0;
				glen_q[i] <= '0;
				obox_q[i] <= '0;
			end
		end else begin
			if (cmd.clear) count_q <= '0;
			if (cmd.add && count_q < CW'(MAX_OBSTACLES)) count_q <= count_q + 1'b1;
			if (cmd.start) begin
				act_q <= (grow_step == '0) ? 4'h0 : 4'hf;
				dir_q <= '0;
				grew_q <= 1'b0;
				ptr_q <= '0;
				hit_q <= 1'b0;
				for (int i = 0; i < 4; i++) glen_q[i] <= '0;
				box_q[0] <= WW'(point_x);
				box_q[2] <= WW'(point_x);
				box_q[1] <= WW'(point_y);
				box_q[3] <= WW'(point_y);
			end
			// snapshot the trial and restart the scan
			if (cmd.load_out) begin
				for (int i = 0; i < 4; i++) trial_q[i] <= tb[i];
				ptr_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.rd_req && !cmd.load_out) ptr_q <= ptr_q + 1'b1;
			if (cmd.check && obst_hit) hit_q <= 1'b1;
			if (cmd.commit) begin
				for (int i = 0; i < 4; i++) box_q[i] <= trial_q[i];
				grew_q <= 1'b1;
				glen_q[dir_q] <= gl_new;
				if (gl_new >= WW'(grow_limit)) act_q[dir_q] <= 1'b0;
			end
			if (cmd.reject) act_q[dir_q] <= 1'b0;
			if (cmd.commit || cmd.reject) dir_q <= nd;
			// result register, frees the working box for the next query
			if (cmd.emit) begin
				for (int i = 0; i < 4; i++) obox_q[i] <= box_q[i][COORD_BITS:0];
				ogrew_q <= grew_q;
			end
		end
	end

	assign grew = ogrew_q;
	assign box_flat = {obox_q[3], obox_q[2], obox_q[1], obox_q[0]};

	`include "safe_box_corridor_grower_assert.svh"
	`SBCG_ASSERT(a_count_max, clk, arst_n, count_q <= CW'(MAX_OBSTACLES), "count over max")
	`SBCG_ASSERT(a_commit_excl, clk, arst_n, !(cmd.commit && cmd.reject), "commit and reject")
	`SBCG_ASSERT(a_start_clears, clk, arst_n, cmd.start |=> !grew_q, "grew not cleared")
endmodule

### hdl/sbcg_ctrl.sv
module sbcg_ctrl import sbcg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	output logic out_valid,
	input logic out_ready,
	input sbcg_sts_t sts,
	output sbcg_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TRIAL = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic ovalid_q;
	logic acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = ovalid_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.clear = acc && opcode == OP_CLEAR;
		cmd.add = acc && opcode == OP_ADD;
		cmd.start = acc && opcode == OP_QUERY;
		cmd.load_out = (state_q == S_TRIAL);
		cmd.rd_req = (state_q == S_READ);
		cmd.check = (state_q == S_CHECK);
		cmd.commit = (state_q == S_DECIDE) && sts.map_ok && !sts.hit;
		cmd.reject = (state_q == S_DECIDE) && !(sts.map_ok && !sts.hit);
		cmd.emit = (state_q == S_DONE) && !sts.any_active && (!ovalid_q || out_ready);
	end

	// output beat: loaded on emit, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// sequencer: per trial, read and check each obstacle in turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (cmd.start) state_q <= S_DONE;
				S_DONE: begin
					if (sts.any_active) state_q <= S_TRIAL;
					else if (cmd.emit) state_q <= S_IDLE;
				end
				S_TRIAL: state_q <= sts.no_obst ? S_DECIDE : S_READ;
				S_READ: state_q <= S_CHECK;
				S_CHECK: state_q <= sts.last_obst ? S_DECIDE : S_READ;
				S_DECIDE: state_q <= S_DONE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "safe_box_corridor_grower_assert.svh"
	`SBCG_ASSERT(a_no_accept_busy, clk, arst_n, (state_q != S_IDLE) |-> !in_ready, "busy ready")
	`SBCG_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid, "out dropped")
	`SBCG_ASSERT(a_decide_once, clk, arst_n, (state_q == S_DECIDE) |=> (state_q == S_DONE), "decide")
endmodule
